// ===== rtl/gwcc_pkg.sv =====
// shared types and constants of the raised-cosine crossfade gain block
package gwcc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

    // register widths
    localparam int GAIN_W      = 16;
    localparam int FRAME_CFG_W = 20;
    localparam int CHAN_CFG_W  = 4;

    // register reset values
    localparam logic [GAIN_W-1:0]      RST_TARGET_GAIN   = 16'd4096;
    localparam logic [FRAME_CFG_W-1:0] RST_REGION_FRAMES = 20'd1024;
    localparam logic [FRAME_CFG_W-1:0] RST_FADE_LENGTH   = 20'd64;
    localparam logic [CHAN_CFG_W-1:0]  RST_CHANNEL_COUNT = 4'd2;

    // Q4.12 unity gain
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd4096;

    // blend entries are Q16, up to and including 1.0
    localparam int BLEND_W = 17;
    localparam logic [BLEND_W-1:0] BLEND_ONE = 17'd65536;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // commands from the controller, at most one per cycle
    typedef struct packed {
        logic take;
        logic prep;
        logic div_step;
        logic rom_rd;
        logic gmul;
        logic gain_ld;
        logic smul;
        logic out_ld;
    } t_dp_cmd;

    // status back to the controller
    typedef struct packed {
        logic new_frame;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/gain_with_cosine_crossfade.sv =====
// top level of the raised-cosine crossfade gain block
// Scales interleaved audio samples of a region of region_frames frames by a per-frame
// gain that eases from unity to target_gain (Q4.12) over the first F frames with a
// raised-cosine blend, holds it, and eases back over the last F frames, where
// F = min(max(fade_length, 1), region_frames / 2). Each result is rounded, saturated to
// SAMPLE_BITS with a clip flag, and flagged on the region's last sample, after which the
// position counters restart. Both channels use valid/stall; configuration is a plain
// write port, to be used only while no transaction is in flight. The first channel of
// each frame passes through the restoring divider that works out the blend phase one
// quotient bit per cycle, followed by the registered table read and the gain multiply;
// every other channel of the frame goes straight to the sample multiply. A stalled
// output holds the next result in place, and one further input transaction may be
// taken while a result waits.
module gain_with_cosine_crossfade #(
    parameter int SAMPLE_BITS       = 24,
    parameter int FRAME_BITS        = 20,
    parameter int MAX_CHANNELS      = 8,
    parameter int BLEND_TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [gwcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gwcc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]       o_sample_out,
    output logic                                o_clipped,
    output logic                                o_region_last
);

    gwcc_pkg::t_dp_cmd w_cmd;
    gwcc_pkg::t_dp_sts w_sts;

    // controller walks prep, divide, table read, gain, multiply, output; later channels of a frame skip to multiply
    gwcc_ctrl #(
        .DIV_STEPS ($clog2(BLEND_TABLE_DEPTH))
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath holds config, counters, divider, blend table and output register
    gwcc_dp #(
        .SAMPLE_BITS       (SAMPLE_BITS),
        .FRAME_BITS        (FRAME_BITS),
        .MAX_CHANNELS      (MAX_CHANNELS),
        .BLEND_TABLE_DEPTH (BLEND_TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample_in   (i_sample_in),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_sample_out  (o_sample_out),
        .o_clipped     (o_clipped),
        .o_region_last (o_region_last)
    );

    // one transaction in work at a time: input stalls right after a take
    a_stall_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transaction was taken");

    // controller issues at most one datapath command per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command at once");

    // a result is loaded only when the output register is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_ld |-> w_sts.out_free)
        else $error("result loaded over a pending output transaction");

endmodule

// ===== rtl/gwcc_blend_rom.sv =====
// raised-cosine blend table, built at elaboration, registered read
module gwcc_blend_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rd,
    input  logic [$clog2(DEPTH)-1:0]          i_addr,
    output logic [gwcc_pkg::BLEND_W-1:0]      o_data
);

    logic [gwcc_pkg::BLEND_W-1:0] w_tab [DEPTH];
    logic [gwcc_pkg::BLEND_W-1:0] r_data;

    // entry q = sin^2(pi/2 * q / DEPTH), sine by truncated taylor series in Q30
    for (genvar q = 0; q < DEPTH; q++) begin : g_ent
        localparam logic [63:0] TH  = (gwcc_pkg::HALF_PI_Q30 * 64'(q)) / DEPTH;
        localparam logic [63:0] TH2 = (TH * TH) >> 30;
        // divisors are (2k)(2k+1) for k = 1..5
        localparam logic [63:0] T1  = ((TH * TH2) >> 30) / 64'd6;
        localparam logic [63:0] T2  = ((T1 * TH2) >> 30) / 64'd20;
        localparam logic [63:0] T3  = ((T2 * TH2) >> 30) / 64'd42;
        localparam logic [63:0] T4  = ((T3 * TH2) >> 30) / 64'd72;
        localparam logic [63:0] T5  = ((T4 * TH2) >> 30) / 64'd110;
        localparam logic [63:0] SN  = TH - T1 + T2 - T3 + T4 - T5;
        localparam logic [63:0] SQ  = (SN * SN + (64'd1 << 43)) >> 44;
        localparam logic [63:0] CAP = (SQ > 64'(gwcc_pkg::BLEND_ONE)) ?
                                      64'(gwcc_pkg::BLEND_ONE) : SQ;
        assign w_tab[q] = CAP[gwcc_pkg::BLEND_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_data <= w_tab[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/gwcc_ctrl.sv =====
// sequencing state machine of the crossfade gain block
module gwcc_ctrl #(
    parameter int DIV_STEPS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gwcc_pkg::t_dp_sts  i_sts,
    output gwcc_pkg::t_dp_cmd  o_cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ROM  = 3'd3;
    localparam logic [2:0] S_GMUL = 3'd4;
    localparam logic [2:0] S_GAIN = 3'd5;
    localparam logic [2:0] S_SMUL = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_sts.new_frame ? S_PREP : S_SMUL;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_ROM;
                end
            end
            S_ROM: begin
                o_cmd.rom_rd = 1'b1;
                n_state      = S_GMUL;
            end
            S_GMUL: begin
                o_cmd.gmul = 1'b1;
                n_state    = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain_ld = 1'b1;
                n_state       = S_SMUL;
            end
            S_SMUL: begin
                o_cmd.smul = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/gwcc_dp.sv =====
// datapath: config registers, position counters, phase divider, gain and sample math
module gwcc_dp #(
    parameter int SAMPLE_BITS       = 24,
    parameter int FRAME_BITS        = 20,
    parameter int MAX_CHANNELS      = 8,
    parameter int BLEND_TABLE_DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [gwcc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [gwcc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample_in,
    input  gwcc_pkg::t_dp_cmd                      i_cmd,
    output gwcc_pkg::t_dp_sts                      o_sts,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]          o_sample_out,
    output logic                                   o_clipped,
    output logic                                   o_region_last
);

    localparam int S   = SAMPLE_BITS;
    localparam int GW  = gwcc_pkg::GAIN_W;
    localparam int FW  = gwcc_pkg::FRAME_CFG_W;
    localparam int BW  = gwcc_pkg::BLEND_W;
    localparam int QB  = $clog2(BLEND_TABLE_DEPTH);
    localparam int CW  = (FRAME_BITS > FW ? FRAME_BITS : FW) + 1;
    localparam int FMB = (FRAME_BITS < FW) ? FRAME_BITS : FW;
    localparam int CPW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHW = $clog2(MAX_CHANNELS) + 2;

    localparam logic [FW-1:0] FMASK   = FW'((64'd1 << FMB) - 64'd1);
    localparam logic [QB:0]   DEPTH_V = (QB+1)'(BLEND_TABLE_DEPTH);
    localparam logic [QB-1:0] Q_MAX   = QB'(BLEND_TABLE_DEPTH - 1);
    localparam logic [CHW-1:0] CH_MAX = CHW'(MAX_CHANNELS);

    // configuration
    logic [GW-1:0]                    r_target_gain;
    logic [FW-1:0]                    r_region_frames;
    logic [FW-1:0]                    r_fade_length;
    logic [gwcc_pkg::CHAN_CFG_W-1:0]  r_channel_count;

    // positions and per-frame gain
    logic [FRAME_BITS-1:0] r_fp;
    logic [CPW-1:0]        r_cp;
    logic [GW-1:0]         r_frame_gain;

    // work registers
    logic signed [S-1:0]   r_sample;
    logic                  r_use_blend;
    logic [FW-1:0]         r_rem;
    logic [QB-1:0]         r_qd;
    logic [GW+BW-1:0]      r_gprod;
    logic                  r_gup;
    logic [S+GW-1:0]       r_sprod;

    // output register
    logic                  r_out_valid;
    logic signed [S-1:0]   r_sample_out;
    logic                  r_clipped;
    logic                  r_region_last;

    // derived fade length and region
    logic [FW-1:0] w_region, w_fl, w_half, w_fe;
    logic [CW-1:0] w_f, w_r, w_fe_c;
    logic          w_in_fade;
    logic [FW-1:0] w_d;
    logic [FW+QB:0] w_dprod;

    assign w_region = (r_region_frames == '0) ? FW'(1) : r_region_frames;
    assign w_fl     = (r_fade_length == '0) ? FW'(1) : r_fade_length;
    assign w_half   = w_region >> 1;
    assign w_fe     = (w_fl < w_half) ? w_fl : w_half;
    assign w_f      = CW'(r_fp);
    assign w_r      = CW'(w_region);
    assign w_fe_c   = CW'(w_fe);

    always_comb begin
        w_in_fade = 1'b0;
        w_d       = '0;
        if (w_fe != '0) begin
            if (w_f < w_fe_c) begin
                w_in_fade = 1'b1;
                w_d       = w_f[FW-1:0];
            end else if (w_f + w_fe_c >= w_r) begin
                w_in_fade = 1'b1;
                // past the region end the distance is zero
                if (w_f <= w_r - CW'(1)) begin
                    w_d = FW'(w_r - CW'(1) - w_f);
                end
            end
        end
    end

    assign w_dprod = {{(QB+1){1'b0}}, w_d} * {{FW{1'b0}}, DEPTH_V};

    // restoring divider step, one quotient bit a cycle
    logic [FW:0] w_rem2;
    logic        w_ge;
    assign w_rem2 = {r_rem, r_qd[QB-1]};
    assign w_ge   = (w_rem2 >= {1'b0, w_fe});

    // blend table
    logic [QB-1:0] w_q;
    logic [BW-1:0] w_blend;
    assign w_q = (r_qd > Q_MAX) ? Q_MAX : r_qd;

    gwcc_blend_rom #(
        .DEPTH (BLEND_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_rd   (i_cmd.rom_rd),
        .i_addr (w_q),
        .o_data (w_blend)
    );

    // gain blend
    logic          w_up;
    logic [GW-1:0] w_delta;
    logic [GW+BW:0] w_gsum;
    logic [GW-1:0] w_rr;
    logic [GW-1:0] w_gain;

    assign w_up    = (r_target_gain >= gwcc_pkg::UNITY_GAIN);
    assign w_delta = w_up ? (r_target_gain - gwcc_pkg::UNITY_GAIN)
                          : (gwcc_pkg::UNITY_GAIN - r_target_gain);
    assign w_gsum  = (GW+BW+1)'(r_gprod) + (GW+BW+1)'(32768);
    assign w_rr    = w_gsum[GW+15:16];
    assign w_gain  = r_gup ? (gwcc_pkg::UNITY_GAIN + w_rr) : (gwcc_pkg::UNITY_GAIN - w_rr);

    // sample magnitude, rounding and saturation
    logic          w_neg;
    logic [S-1:0]  w_mag;
    logic [S+GW:0] w_ssum;
    logic [S+4:0]  w_rnd;
    logic [S+4:0]  w_lim;
    logic          w_clip;
    logic [S-1:0]  w_res_mag;
    logic [S-1:0]  w_res;

    assign w_neg  = r_sample[S-1];
    assign w_mag  = w_neg ? (S'(0) - S'(r_sample)) : S'(r_sample);
    assign w_ssum = (S+GW+1)'(r_sprod) + (S+GW+1)'(2048);
    assign w_rnd  = w_ssum[S+GW:12];
    assign w_lim  = w_neg ? ((S+5)'(1) << (S-1)) : (((S+5)'(1) << (S-1)) - (S+5)'(1));
    assign w_clip = (w_rnd > w_lim);
    assign w_res_mag = w_clip ? w_lim[S-1:0] : w_rnd[S-1:0];
    assign w_res     = w_neg ? (S'(0) - w_res_mag) : w_res_mag;

    // position update
    logic [CHW-1:0]        w_cc, w_ch, w_cp1;
    logic [CW-1:0]         w_fp1;
    logic                  w_frame_end, w_last;

    assign w_cc = CHW'(r_channel_count);
    always_comb begin
        w_ch = (w_cc == '0) ? CHW'(1) : w_cc;
        if (w_ch > CH_MAX) begin
            w_ch = CH_MAX;
        end
    end
    assign w_cp1       = CHW'(r_cp) + CHW'(1);
    assign w_fp1       = w_f + CW'(1);
    assign w_frame_end = (w_cp1 >= w_ch);
    assign w_last      = (w_fp1 >= w_r) && w_frame_end;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_gain   <= gwcc_pkg::RST_TARGET_GAIN;
            r_region_frames <= gwcc_pkg::RST_REGION_FRAMES;
            r_fade_length   <= gwcc_pkg::RST_FADE_LENGTH;
            r_channel_count <= gwcc_pkg::RST_CHANNEL_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gwcc_pkg::REG_TARGET_GAIN:   r_target_gain   <= i_cfg_data[GW-1:0];
                gwcc_pkg::REG_REGION_FRAMES: r_region_frames <= i_cfg_data[FW-1:0] & FMASK;
                gwcc_pkg::REG_FADE_LENGTH:   r_fade_length   <= i_cfg_data[FW-1:0] & FMASK;
                gwcc_pkg::REG_CHANNEL_COUNT: begin
                    r_channel_count <= i_cfg_data[gwcc_pkg::CHAN_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // positions, frame gain, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp         <= '0;
            r_cp         <= '0;
            r_frame_gain <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.gain_ld) begin
                r_frame_gain <= r_use_blend ? w_gain : r_target_gain;
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
                if (w_last) begin
                    r_fp <= '0;
                    r_cp <= '0;
                end else if (w_frame_end) begin
                    r_cp <= '0;
                    r_fp <= r_fp + 1'b1;
                end else begin
                    r_cp <= w_cp1[CPW-1:0];
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= i_sample_in;
        end
        if (i_cmd.prep) begin
            r_use_blend <= w_in_fade;
            r_rem       <= w_dprod[FW+QB-1:QB];
            r_qd        <= w_dprod[QB-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? FW'(w_rem2 - {1'b0, w_fe}) : w_rem2[FW-1:0];
            r_qd  <= {r_qd[QB-2:0], w_ge};
        end
        if (i_cmd.gmul) begin
            r_gprod <= {{BW{1'b0}}, w_delta} * {{GW{1'b0}}, w_blend};
            r_gup   <= w_up;
        end
        if (i_cmd.smul) begin
            r_sprod <= {{GW{1'b0}}, w_mag} * {{S{1'b0}}, r_frame_gain};
        end
        if (i_cmd.out_ld) begin
            r_sample_out  <= w_res;
            r_clipped     <= w_clip;
            r_region_last <= w_last;
        end
    end

    assign o_sts.new_frame = (r_cp == '0);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_sample_out  = r_sample_out;
    assign o_clipped     = r_clipped;
    assign o_region_last = r_region_last;

endmodule
